>>> src/aesccm_pkg.sv
// Shared types, constants and AES helper functions for the AES-128 CCM engine.
// Used by the front end, the sequencer, the AES round unit and the top level.
package aesccm_pkg;

    typedef enum logic [1:0] {
        CMD_HDR = 2'd0,
        CMD_AAD = 2'd1,
        CMD_PAY = 2'd2,
        CMD_TAG = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_AAD     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_TAG     = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        DST_MAC = 2'd0,
        DST_KS  = 2'd1,
        DST_S0  = 2'd2
    } aes_dst_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR,
        ST_HDR_SETUP,
        ST_AES,
        ST_WAIT,
        ST_BYTE,
        ST_AAD_END,
        ST_PAY_OUT,
        ST_FIN,
        ST_TAG_OUT1,
        ST_TAG_OUT2,
        ST_VERIFY,
        ST_REJ_OUT
    } seq_state_t;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_TAG_LEN  = 2'd2;
    localparam logic [1:0] REG_MODE     = 2'd3;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_TAG     = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REJECT   = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    localparam logic [4:0] TAG_LEN_RESET = 5'd8;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] data_word;
        logic [39:0] nonce_top;
        logic [4:0]  aad_len;
        logic [15:0] message_len;
        logic [3:0]  byte_count;
        logic        hdr_reject;
    } item_t;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  bytes;
        logic [1:0]  kind;
        logic [1:0]  status;
        logic        fin;
    } res_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES round; byte 0 of the state sits in bits 127..120.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last_round);
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, x;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[c*4+j] = SBOX[s[127 - 8*((((c + j) & 3) * 4) + j) -: 8]];
            end
        end
        if (!last_round) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[c*4];
                a1 = t[c*4+1];
                a2 = t[c*4+2];
                a3 = t[c*4+3];
                x  = a0 ^ a1 ^ a2 ^ a3;
                t[c*4]   = a0 ^ x ^ xt(a0 ^ a1);
                t[c*4+1] = a1 ^ x ^ xt(a1 ^ a2);
                t[c*4+2] = a2 ^ x ^ xt(a2 ^ a3);
                t[c*4+3] = a3 ^ x ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = t[i] ^ rk[127 - 8*i -: 8];
        end
        return r;
    endfunction

    // Next round key from the current one.
    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rcon);
        logic [31:0] tmp, w0, w1, w2, w3;
        tmp = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        w0  = rk[127:96] ^ tmp;
        w1  = rk[95:64] ^ w0;
        w2  = rk[63:32] ^ w1;
        w3  = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // Tag length clamped to 4..16 and made even.
    function automatic logic [4:0] eff_m(input logic [4:0] tag_len);
        logic [4:0] m;
        m = tag_len;
        if (m < 5'd4) begin
            m = 5'd4;
        end
        if (m > 5'd16) begin
            m = 5'd16;
        end
        return {m[4:1], 1'b0};
    endfunction

    // Keeps the top n bytes of a 64-bit word, n from 0 to 8.
    function automatic logic [63:0] mask64(input logic [3:0] n);
        return {64{1'b1}} << {4'd8 - n, 3'b000};
    endfunction

    // Keeps the top m bytes of a 128-bit block, m from 4 to 16.
    function automatic logic [127:0] mask128(input logic [4:0] m);
        return {128{1'b1}} << {5'd16 - m, 3'b000};
    endfunction

endpackage

>>> src/aesccm_aes.sv
// Iterative AES-128 encryption unit: one round per cycle, round keys on the fly.
// Depends on aesccm_pkg for the S-box, round and key schedule functions.
module aesccm_aes (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] din,
    output logic         done,
    output logic [127:0] dout
);
    import aesccm_pkg::*;

    logic         busy_reg;
    logic         done_reg;
    logic [3:0]   round_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] st_reg;
    logic [127:0] rk_reg;
    logic [127:0] rk_next;

    assign rk_next = key_step(rk_reg, rcon_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= 4'd1;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 4'd1;
                if (round_reg == 4'd10)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            st_reg   <= din ^ key;
            rk_reg   <= key;
            rcon_reg <= 8'h01;
        end
        else if (busy_reg)
        begin
            st_reg   <= aes_round(st_reg, rk_next, round_reg == 4'd10);
            rk_reg   <= rk_next;
            rcon_reg <= xt(rcon_reg);
        end
    end

    assign done = done_reg;
    assign dout = st_reg;

endmodule

>>> src/aesccm_front.sv
// Input side: unpacks stream items, clamps the byte count, flags oversize headers
// and holds them in a two-entry queue for the sequencer. Depends on aesccm_pkg.
module aesccm_front #(
    parameter int MAX_AAD_BYTES = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  aesccm_pkg::cmd_t    in_cmd,
    input  logic [63:0]         in_data_word,
    input  logic [39:0]         in_nonce_top,
    input  logic [4:0]          in_aad_len,
    input  logic [15:0]         in_message_len,
    input  logic [3:0]          in_byte_count,
    output logic                q_valid,
    output aesccm_pkg::item_t   q_item,
    input  logic                q_pop
);
    import aesccm_pkg::*;

    localparam logic [4:0] MAX_AAD = 5'(MAX_AAD_BYTES);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      cls;
    logic       push;
    logic       pop;

    always_comb
    begin
        cls.cmd         = in_cmd;
        cls.data_word   = in_data_word;
        cls.nonce_top   = in_nonce_top;
        cls.aad_len     = in_aad_len;
        cls.message_len = in_message_len;
        cls.byte_count  = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
        cls.hdr_reject  = (in_aad_len > MAX_AAD);
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> src/aesccm_back.sv
// Sequencer: carries out queued items a byte per cycle when no AES run stalls it, drives the
// shared AES unit for CBC-MAC and counter blocks, and holds the result register. Uses aesccm_pkg.
module aesccm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  aesccm_pkg::item_t   q_item,
    output logic                q_pop,
    input  logic [127:0]        key,
    input  logic [4:0]          tag_len,
    input  logic                mode,
    output logic                out_valid,
    input  logic                out_ready,
    output aesccm_pkg::res_t    out_res
);
    import aesccm_pkg::*;

    seq_state_t   state_reg, state_next;
    seq_state_t   ret_reg, ret_next;
    aes_dst_t     dst_reg, dst_next;
    phase_t       phase_reg;
    item_t        item_reg;
    logic [63:0]  dw_sh_reg;
    logic [3:0]   k_reg;
    logic [3:0]   cnt_reg;
    logic [63:0]  w_reg;
    logic [127:0] cbc_reg;
    logic [127:0] ks_reg;
    logic [127:0] s0_reg;
    logic [127:0] buf_reg;
    logic [127:0] rt_reg;
    logic [103:0] nonce_reg;
    logic [15:0]  ctr_reg;
    logic [4:0]   fill_reg;
    logic [4:0]   aad_left_reg;
    logic [15:0]  pay_left_reg;
    logic         ks_ok_reg;
    logic         out_valid_reg;
    res_t         out_reg;

    logic         aes_start;
    logic [127:0] aes_in;
    logic         aes_done;
    logic [127:0] aes_out;
    logic         out_free;
    logic         out_load;
    res_t         res;
    logic [4:0]   m;
    logic [3:0]   f;
    logic [6:0]   fpos;
    logic [7:0]   b;
    logic [7:0]   o;
    logic         in_loop;
    logic         need_ks;
    logic [127:0] tag_t;
    logic [3:0]   tag_part;
    logic [3:0]   m_low;

    aesccm_aes u_aes (
        .clk   (clk),
        .rst_n (rst_n),
        .start (aes_start),
        .key   (key),
        .din   (aes_in),
        .done  (aes_done),
        .dout  (aes_out)
    );

    assign m        = eff_m(tag_len);
    assign f        = fill_reg[3:0];
    assign fpos     = {~f, 3'b000};
    assign b        = dw_sh_reg[63:56];
    assign o        = b ^ ks_reg[fpos +: 8];
    assign tag_t    = cbc_reg ^ s0_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign tag_part = (m > 5'd8) ? 4'd8 : m[3:0];
    assign m_low    = 4'(m - 5'd8);

    always_comb
    begin
        in_loop = 1'b0;
        case (item_reg.cmd)
            CMD_AAD: in_loop = (k_reg < item_reg.byte_count) && (aad_left_reg != 5'd0);
            CMD_PAY: in_loop = (k_reg < item_reg.byte_count) && (pay_left_reg != 16'd0);
            CMD_TAG: in_loop = (k_reg < item_reg.byte_count) && (fill_reg < m);
            default: in_loop = 1'b0;
        endcase
    end

    assign need_ks = (item_reg.cmd == CMD_PAY) && in_loop && (f == 4'd0) && !ks_ok_reg;

    // Next state, with the target and return point of each AES run.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        dst_next   = dst_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.cmd)
                        CMD_HDR: state_next = ST_HDR;
                        CMD_AAD: state_next = (phase_reg == PH_AAD) ? ST_BYTE : ST_IDLE;
                        CMD_PAY: state_next = (phase_reg == PH_PAYLOAD) ? ST_BYTE : ST_IDLE;
                        CMD_TAG: state_next = (phase_reg == PH_TAG) ? ST_BYTE : ST_IDLE;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HDR:
            begin
                if (item_reg.hdr_reject)
                begin
                    state_next = ST_REJ_OUT;
                end
                else
                begin
                    state_next = ST_AES;
                    dst_next   = DST_MAC;
                    ret_next   = ST_HDR_SETUP;
                end
            end
            ST_HDR_SETUP:
            begin
                if (item_reg.aad_len == 5'd0 && item_reg.message_len == 16'd0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_AES:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (aes_done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_BYTE:
            begin
                case (item_reg.cmd)
                    CMD_AAD:
                    begin
                        if (in_loop)
                        begin
                            if (f == 4'd15)
                            begin
                                state_next = ST_AES;
                                dst_next   = DST_MAC;
                                ret_next   = ST_BYTE;
                            end
                        end
                        else if (aad_left_reg == 5'd0)
                        begin
                            if (fill_reg != 5'd0)
                            begin
                                state_next = ST_AES;
                                dst_next   = DST_MAC;
                                ret_next   = ST_AAD_END;
                            end
                            else
                            begin
                                state_next = ST_AAD_END;
                            end
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_PAY:
                    begin
                        if (in_loop)
                        begin
                            if (need_ks)
                            begin
                                state_next = ST_AES;
                                dst_next   = DST_KS;
                                ret_next   = ST_BYTE;
                            end
                            else if (f == 4'd15)
                            begin
                                state_next = ST_AES;
                                dst_next   = DST_MAC;
                                ret_next   = ST_BYTE;
                            end
                        end
                        else if (cnt_reg != 4'd0)
                        begin
                            state_next = ST_PAY_OUT;
                        end
                        else
                        begin
                            state_next = (pay_left_reg == 16'd0) ? ST_FIN : ST_IDLE;
                        end
                    end
                    CMD_TAG:
                    begin
                        if (!in_loop)
                        begin
                            if (fill_reg >= m)
                            begin
                                state_next = ST_AES;
                                dst_next   = DST_S0;
                                ret_next   = ST_VERIFY;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_AAD_END:
            begin
                state_next = (pay_left_reg == 16'd0) ? ST_FIN : ST_IDLE;
            end
            ST_PAY_OUT:
            begin
                if (out_free)
                begin
                    state_next = (pay_left_reg == 16'd0) ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (fill_reg != 5'd0)
                begin
                    state_next = ST_AES;
                    dst_next   = DST_MAC;
                    ret_next   = ST_FIN;
                end
                else if (!mode)
                begin
                    state_next = ST_AES;
                    dst_next   = DST_S0;
                    ret_next   = ST_TAG_OUT1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TAG_OUT1:
            begin
                if (out_free)
                begin
                    state_next = (m > 5'd8) ? ST_TAG_OUT2 : ST_IDLE;
                end
            end
            ST_TAG_OUT2, ST_VERIFY, ST_REJ_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs: queue pop, AES start and operand, and the result with its load.
    always_comb
    begin
        q_pop     = (state_reg == ST_IDLE) && q_valid;
        aes_start = (state_reg == ST_AES);
        if (dst_reg == DST_MAC)
        begin
            aes_in = cbc_reg ^ buf_reg;
        end
        else
        begin
            aes_in = {8'h01, nonce_reg, (dst_reg == DST_KS) ? ctr_reg : 16'd0};
        end
        res.word   = 64'd0;
        res.bytes  = 4'd0;
        res.kind   = KIND_STATUS;
        res.status = STATUS_OK;
        res.fin    = 1'b1;
        out_load   = 1'b0;
        case (state_reg)
            ST_PAY_OUT:
            begin
                out_load  = out_free;
                res.word  = w_reg;
                res.bytes = cnt_reg;
                res.kind  = KIND_PAYLOAD;
                res.fin   = !((pay_left_reg == 16'd0) && !mode);
            end
            ST_TAG_OUT1:
            begin
                out_load  = out_free;
                res.word  = tag_t[127:64] & mask64(tag_part);
                res.bytes = tag_part;
                res.kind  = KIND_TAG;
                res.fin   = (m <= 5'd8);
            end
            ST_TAG_OUT2:
            begin
                out_load  = out_free;
                res.word  = tag_t[63:0] & mask64(m_low);
                res.bytes = m_low;
                res.kind  = KIND_TAG;
            end
            ST_VERIFY:
            begin
                out_load   = out_free;
                res.status = (((tag_t ^ rt_reg) & mask128(m)) != 128'd0) ?
                             STATUS_MISMATCH : STATUS_OK;
            end
            ST_REJ_OUT:
            begin
                out_load   = out_free;
                res.status = STATUS_REJECT;
            end
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            dst_reg       <= DST_MAC;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
            ks_ok_reg     <= 1'b0;
            fill_reg      <= 5'd0;
            aad_left_reg  <= 5'd0;
            pay_left_reg  <= 16'd0;
            ctr_reg       <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            dst_reg   <= dst_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_HDR:
                begin
                    if (item_reg.hdr_reject)
                    begin
                        phase_reg <= PH_IDLE;
                    end
                end
                ST_HDR_SETUP:
                begin
                    ctr_reg      <= 16'd0;
                    pay_left_reg <= item_reg.message_len;
                    aad_left_reg <= item_reg.aad_len;
                    ks_ok_reg    <= 1'b0;
                    if (item_reg.aad_len != 5'd0)
                    begin
                        fill_reg  <= 5'd2;
                        phase_reg <= PH_AAD;
                    end
                    else
                    begin
                        phase_reg <= PH_PAYLOAD;
                    end
                end
                ST_WAIT:
                begin
                    if (aes_done)
                    begin
                        if (dst_reg == DST_MAC)
                        begin
                            fill_reg  <= 5'd0;
                            ks_ok_reg <= 1'b0;
                        end
                        else if (dst_reg == DST_KS)
                        begin
                            ks_ok_reg <= 1'b1;
                        end
                    end
                end
                ST_BYTE:
                begin
                    if (need_ks)
                    begin
                        ctr_reg <= ctr_reg + 16'd1;
                    end
                    else if (in_loop)
                    begin
                        fill_reg <= fill_reg + 5'd1;
                        if (item_reg.cmd == CMD_AAD)
                        begin
                            aad_left_reg <= aad_left_reg - 5'd1;
                        end
                        if (item_reg.cmd == CMD_PAY)
                        begin
                            pay_left_reg <= pay_left_reg - 16'd1;
                        end
                    end
                end
                ST_AAD_END:
                begin
                    phase_reg <= PH_PAYLOAD;
                end
                ST_FIN:
                begin
                    if (fill_reg == 5'd0)
                    begin
                        phase_reg <= mode ? PH_TAG : PH_IDLE;
                    end
                end
                ST_VERIFY:
                begin
                    if (out_free)
                    begin
                        fill_reg  <= 5'd0;
                        phase_reg <= PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    item_reg  <= q_item;
                    dw_sh_reg <= q_item.data_word;
                    k_reg     <= 4'd0;
                    cnt_reg   <= 4'd0;
                    w_reg     <= 64'd0;
                end
            end
            ST_HDR:
            begin
                nonce_reg <= {item_reg.nonce_top, item_reg.data_word};
                cbc_reg   <= 128'd0;
                buf_reg   <= {1'b0, item_reg.aad_len != 5'd0, 3'(m[4:1] - 4'd1), 3'b001,
                              item_reg.nonce_top, item_reg.data_word, item_reg.message_len};
            end
            ST_HDR_SETUP:
            begin
                if (item_reg.aad_len != 5'd0)
                begin
                    buf_reg <= {8'h00, 3'b000, item_reg.aad_len, 112'd0};
                end
            end
            ST_WAIT:
            begin
                if (aes_done)
                begin
                    case (dst_reg)
                        DST_MAC:
                        begin
                            cbc_reg <= aes_out;
                            buf_reg <= 128'd0;
                        end
                        DST_KS: ks_reg <= aes_out;
                        DST_S0: s0_reg <= aes_out;
                        default: s0_reg <= aes_out;
                    endcase
                end
            end
            ST_BYTE:
            begin
                if (in_loop && !need_ks)
                begin
                    k_reg     <= k_reg + 4'd1;
                    dw_sh_reg <= {dw_sh_reg[55:0], 8'h00};
                    case (item_reg.cmd)
                        CMD_AAD: buf_reg[fpos +: 8] <= b;
                        CMD_PAY:
                        begin
                            buf_reg[fpos +: 8]                <= mode ? o : b;
                            w_reg[{~k_reg[2:0], 3'b000} +: 8] <= o;
                            cnt_reg                           <= cnt_reg + 4'd1;
                        end
                        CMD_TAG: rt_reg[fpos +: 8] <= b;
                        default: k_reg <= k_reg;
                    endcase
                end
            end
            ST_FIN:
            begin
                if (fill_reg == 5'd0 && mode)
                begin
                    rt_reg <= 128'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

>>> src/aes_ccm_authenticated_cipher.sv
// AES-128 CCM engine. The sequencer takes the bytes of an item one at a time and runs each AES
// block on the shared round unit; a keystream block also steps the counter. Closing a message
// runs the AES unit for the tag, or for a verify after the last tag byte. A result is registered
// and valid in the cycle after the step that makes it, and a two-item input queue can still
// accept items while a result waits. Reset is asynchronous, active low: idle, key 0, tag 8, encrypt.
module aes_ccm_authenticated_cipher #(
    parameter int MAX_AAD_BYTES = 30
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bits: data_word[63:0], nonce_top[103:64], aad_len[108:104],
    // message_len[124:109], byte_count[128:125], zeros above
    input  logic [135:0] s_axis_tdata,
    // bits: cmd[1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bits: out_word[63:0], out_bytes[67:64], status[69:68], zeros above
    output logic [71:0]  m_axis_tdata,
    // bits: out_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import aesccm_pkg::*;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [4:0]  tag_len_reg;
    logic        mode_reg;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;
    res_t        out_res;
    logic        unused_last;

    // Section ends follow the header counts; the last marker carries no extra meaning.
    assign unused_last = s_axis_tlast;
    assign cfg_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= 64'd0;
            key_low_reg  <= 64'd0;
            tag_len_reg  <= TAG_LEN_RESET;
            mode_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_TAG_LEN:  tag_len_reg  <= cfg_data[4:0];
                REG_MODE:     mode_reg     <= cfg_data[0];
                default:      mode_reg     <= mode_reg;
            endcase
        end
    end

    aesccm_front #(
        .MAX_AAD_BYTES (MAX_AAD_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_cmd         (cmd_t'(s_axis_tuser)),
        .in_data_word   (s_axis_tdata[63:0]),
        .in_nonce_top   (s_axis_tdata[103:64]),
        .in_aad_len     (s_axis_tdata[108:104]),
        .in_message_len (s_axis_tdata[124:109]),
        .in_byte_count  (s_axis_tdata[128:125]),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    aesccm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .key       ({key_high_reg, key_low_reg}),
        .tag_len   (tag_len_reg),
        .mode      (mode_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.status, out_res.bytes, out_res.word};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.fin;

endmodule

>>> tb/aes_ccm_authenticated_cipher_tb.sv
// Self-checking testbench for the AES-128 CCM engine (aes_ccm_authenticated_cipher).
// Depends on aesccm_pkg for command, register, kind and status codes; it predicts
// every result with its own AES and CCM model and checks the output stream against it.
module aes_ccm_authenticated_cipher_tb;
    import aesccm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        cmd_t        cmd;
        logic [63:0] data_word;
        logic [39:0] nonce_top;
        logic [4:0]  aad_len;
        logic [15:0] message_len;
        logic [3:0]  byte_count;
        logic        last;
    } ccm_item_t;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  bytes;
        logic [1:0]  kind;
        logic [1:0]  status;
        logic        fin;
    } ccm_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;

    aes_ccm_authenticated_cipher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Model state of the engine.
    logic [63:0]  mdl_key_hi, mdl_key_lo;
    logic [4:0]   mdl_tag_len;
    logic         mdl_mode;
    logic [7:0]   mac_state [16];
    logic [7:0]   ks_block [16];
    logic [7:0]   nonce_b [13];
    logic [7:0]   blk_buf [16];
    logic [7:0]   rx_tag [16];
    logic [15:0]  ctr_val, pay_left;
    logic [4:0]   fill_cnt, aad_left;
    phase_t       mdl_phase;

    ccm_item_t    pending_items [$];
    ccm_result_t  expected_results [$];

    int  send_idle_pct, recv_idle_pct;
    bit  hold_input;
    int  quiet_cycles;
    bit  failed;

    function automatic logic [7:0] gmul2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic void block_cipher(input logic [7:0] blk_in [16],
                                         output logic [7:0] blk_out [16]);
        logic [7:0] rk [176];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] tmp [4];
        logic [7:0] rcon, f, a0, a1, a2, a3, x;
        rcon = 8'h01;
        for (int i = 0; i < 8; i++) begin
            rk[i]     = mdl_key_hi[63 - 8*i -: 8];
            rk[8 + i] = mdl_key_lo[63 - 8*i -: 8];
        end
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) begin
                tmp[j] = rk[i - 4 + j];
            end
            if ((i % 16) == 0) begin
                f = tmp[0];
                tmp[0] = SBOX[tmp[1]] ^ rcon;
                tmp[1] = SBOX[tmp[2]];
                tmp[2] = SBOX[tmp[3]];
                tmp[3] = SBOX[f];
                rcon = gmul2(rcon);
            end
            for (int j = 0; j < 4; j++) begin
                rk[i + j] = rk[i - 16 + j] ^ tmp[j];
            end
        end
        for (int i = 0; i < 16; i++) begin
            s[i] = blk_in[i] ^ rk[i];
        end
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++) begin
                for (int j = 0; j < 4; j++) begin
                    t[c*4 + j] = SBOX[s[((c + j) % 4) * 4 + j]];
                end
            end
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    t[c*4]   = a0 ^ x ^ gmul2(a0 ^ a1);
                    t[c*4+1] = a1 ^ x ^ gmul2(a1 ^ a2);
                    t[c*4+2] = a2 ^ x ^ gmul2(a2 ^ a3);
                    t[c*4+3] = a3 ^ x ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) begin
                s[i] = t[i] ^ rk[r*16 + i];
            end
        end
        blk_out = s;
    endfunction

    function automatic int tag_bytes();
        int m;
        m = mdl_tag_len;
        if (m < 4) m = 4;
        if (m > 16) m = 16;
        return m & ~1;
    endfunction

    function automatic void fold_block();
        for (int i = 0; i < 16; i++) begin
            mac_state[i] ^= blk_buf[i];
            blk_buf[i] = 8'h00;
        end
        block_cipher(mac_state, mac_state);
        fill_cnt = 0;
    endfunction

    function automatic void ctr_keystream(input logic [15:0] ctr, output logic [7:0] dst [16]);
        logic [7:0] a [16];
        a[0] = 8'h01;
        for (int i = 0; i < 13; i++) begin
            a[1 + i] = nonce_b[i];
        end
        a[14] = ctr[15:8];
        a[15] = ctr[7:0];
        block_cipher(a, dst);
    endfunction

    function automatic void auth_tag(output logic [7:0] t [16]);
        logic [7:0] s0 [16];
        ctr_keystream(16'd0, s0);
        for (int i = 0; i < 16; i++) begin
            t[i] = mac_state[i] ^ s0[i];
        end
    endfunction

    function automatic void push_result(input logic [63:0] w, input int nb,
                                        input logic [1:0] kind, input logic [1:0] st);
        ccm_result_t r;
        r.word = w; r.bytes = nb[3:0]; r.kind = kind; r.status = st; r.fin = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void close_message();
        logic [7:0]  t [16];
        logic [63:0] w;
        int m, part;
        if (fill_cnt > 0) fold_block();
        fill_cnt = 0;
        if (!mdl_mode) begin
            m = tag_bytes();
            auth_tag(t);
            part = (m > 8) ? 8 : m;
            w = '0;
            for (int i = 0; i < part; i++) w[63 - 8*i -: 8] = t[i];
            push_result(w, part, KIND_TAG, STATUS_OK);
            if (m > 8) begin
                w = '0;
                for (int i = 8; i < m; i++) w[63 - 8*(i-8) -: 8] = t[i];
                push_result(w, m - 8, KIND_TAG, STATUS_OK);
            end
            mdl_phase = PH_IDLE;
        end else begin
            for (int i = 0; i < 16; i++) rx_tag[i] = 8'h00;
            mdl_phase = PH_TAG;
        end
    endfunction

    function automatic void predict_ccm(input ccm_item_t it);
        int bc, n_before, m, cnt, fidx;
        logic [63:0] w;
        logic [7:0]  b, o;
        logic [7:0]  t [16];
        bit          diff;
        n_before = expected_results.size();
        bc = (it.byte_count > 8) ? 8 : it.byte_count;
        case (it.cmd)
            CMD_HDR: begin
                if (it.aad_len > 5'd30) begin
                    mdl_phase = PH_IDLE;
                    push_result('0, 0, KIND_STATUS, STATUS_REJECT);
                end else begin
                    for (int k = 0; k < 5; k++) nonce_b[k] = it.nonce_top[39 - 8*k -: 8];
                    for (int k = 0; k < 8; k++) nonce_b[5 + k] = it.data_word[63 - 8*k -: 8];
                    for (int i = 0; i < 16; i++) mac_state[i] = 8'h00;
                    blk_buf[0] = ((it.aad_len != 0) ? 8'h40 : 8'h00)
                               | 8'(((tag_bytes() - 2) / 2) << 3) | 8'h01;
                    for (int i = 0; i < 13; i++) blk_buf[1 + i] = nonce_b[i];
                    blk_buf[14] = it.message_len[15:8];
                    blk_buf[15] = it.message_len[7:0];
                    fold_block();
                    ctr_val = 0;
                    pay_left = it.message_len;
                    aad_left = it.aad_len;
                    if (it.aad_len > 0) begin
                        blk_buf[0] = 8'h00;
                        blk_buf[1] = {3'b000, it.aad_len};
                        fill_cnt = 2;
                        mdl_phase = PH_AAD;
                    end else begin
                        mdl_phase = PH_PAYLOAD;
                        if (pay_left == 0) close_message();
                    end
                end
            end
            CMD_AAD: begin
                if (mdl_phase == PH_AAD) begin
                    for (int k = 0; k < bc && aad_left > 0; k++) begin
                        blk_buf[fill_cnt % 16] = it.data_word[63 - 8*k -: 8];
                        fill_cnt++;
                        aad_left--;
                        if (fill_cnt >= 16) fold_block();
                    end
                    if (aad_left == 0) begin
                        if (fill_cnt > 0) fold_block();
                        mdl_phase = PH_PAYLOAD;
                        if (pay_left == 0) close_message();
                    end
                end
            end
            CMD_PAY: begin
                if (mdl_phase == PH_PAYLOAD) begin
                    w = '0;
                    cnt = 0;
                    for (int k = 0; k < bc && pay_left > 0; k++) begin
                        b = it.data_word[63 - 8*k -: 8];
                        fidx = fill_cnt % 16;
                        if (fidx == 0) begin
                            ctr_val++;
                            ctr_keystream(ctr_val, ks_block);
                        end
                        o = b ^ ks_block[fidx];
                        blk_buf[fidx] = mdl_mode ? o : b;
                        fill_cnt = 5'(fidx + 1);
                        w[63 - 8*k -: 8] = o;
                        cnt++;
                        pay_left--;
                        if (fill_cnt >= 16) fold_block();
                    end
                    if (cnt > 0) push_result(w, cnt, KIND_PAYLOAD, STATUS_OK);
                    if (pay_left == 0) close_message();
                end
            end
            default: begin
                if (mdl_phase == PH_TAG) begin
                    m = tag_bytes();
                    for (int k = 0; k < bc && fill_cnt < m; k++) begin
                        rx_tag[fill_cnt % 16] = it.data_word[63 - 8*k -: 8];
                        fill_cnt++;
                    end
                    if (fill_cnt >= m) begin
                        auth_tag(t);
                        diff = 0;
                        for (int i = 0; i < m; i++) if (t[i] != rx_tag[i]) diff = 1;
                        push_result('0, 0, KIND_STATUS, diff ? STATUS_MISMATCH : STATUS_OK);
                        fill_cnt = 0;
                        mdl_phase = PH_IDLE;
                    end
                end
            end
        endcase
        if (expected_results.size() > n_before)
            expected_results[expected_results.size() - 1].fin = 1'b1;
    endfunction

    function automatic ccm_item_t make_item(input cmd_t cmd, input logic [63:0] dw,
                                            input int bc, input bit lst);
        ccm_item_t it;
        it.cmd = cmd; it.data_word = dw; it.byte_count = bc[3:0]; it.last = lst;
        it.nonce_top = 40'({$urandom, $urandom});
        it.aad_len = 5'($urandom); it.message_len = 16'($urandom);
        return it;
    endfunction

    function automatic ccm_item_t make_header(input int alen, input int mlen);
        ccm_item_t it;
        it = make_item(CMD_HDR, {$urandom, $urandom}, $urandom_range(0, 15), 1'b0);
        it.aad_len = alen[4:0];
        it.message_len = mlen[15:0];
        return it;
    endfunction

    // Queues a well-formed message; the chunk sizes vary and may run past the section end.
    task automatic queue_message(input int alen, input int mlen, input bit decrypt,
                                 input bit good_tag);
        int left, bc;
        pending_items.push_back(make_header(alen, mlen));
        left = alen;
        while (left > 0) begin
            bc = $urandom_range(1, 8);
            pending_items.push_back(make_item(CMD_AAD, {$urandom, $urandom}, bc, bc >= left));
            left -= bc;
        end
        left = mlen;
        while (left > 0) begin
            bc = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
            pending_items.push_back(make_item(CMD_PAY, {$urandom, $urandom}, bc, bc >= left));
            left -= (bc > 8) ? 8 : bc;
        end
        if (decrypt) begin
            // Tag chunks are random; the driver replaces them with the right tag when asked.
            left = 16;
            while (left > 0) begin
                bc = $urandom_range(2, 8);
                pending_items.push_back(make_item(CMD_TAG, {$urandom, $urandom}, bc,
                                                  bc >= left));
                pending_items[pending_items.size() - 1].last = good_tag;
                left -= bc;
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KEY_HIGH: mdl_key_hi = val;
            REG_KEY_LOW:  mdl_key_lo = val;
            REG_TAG_LEN:  mdl_tag_len = val[4:0];
            default:      mdl_mode = val[0];
        endcase
    endtask

    task automatic drain_engine();
        while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver. A tag chunk whose last flag is set while the message is meant to verify
    // carries the bytes of the true tag, worked out just before the transfer.
    logic [7:0] true_tag [16];
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                ccm_item_t done_it;
                done_it = pending_items.pop_front();
                predict_ccm(done_it);
            end
            if (pending_items.size() > 0 && !hold_input
                && (!s_axis_tvalid || s_axis_tready)
                && ($urandom_range(0, 99) >= send_idle_pct)) begin
                ccm_item_t it;
                it = pending_items[0];
                if (it.cmd == CMD_TAG && mdl_phase == PH_TAG && it.last) begin
                    // Substitute the real tag for a chunk that is meant to verify.
                    auth_tag(true_tag);
                    for (int k = 0; k < 8; k++)
                        if (fill_cnt + k < 16)
                            it.data_word[63 - 8*k -: 8] = true_tag[fill_cnt + k];
                    pending_items[0] = it;
                end
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, it.byte_count, it.message_len, it.aad_len,
                                  it.nonce_top, it.data_word};
                s_axis_tuser  <= it.cmd;
                s_axis_tlast  <= it.last;
            end else if (!s_axis_tvalid || s_axis_tready) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stalls.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            quiet_cycles  <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word=%h bytes=%0d kind=%0d status=%0d",
                             $time, m_axis_tdata[63:0], m_axis_tdata[67:64],
                             m_axis_tuser, m_axis_tdata[69:68]);
                    failed = 1'b1;
                end else begin
                    ccm_result_t e;
                    e = expected_results.pop_front();
                    if (m_axis_tdata[63:0] !== e.word || m_axis_tdata[67:64] !== e.bytes
                        || m_axis_tuser !== e.kind || m_axis_tdata[69:68] !== e.status
                        || m_axis_tlast !== e.fin || m_axis_tdata[71:70] !== 2'b00) begin
                        $display("%0t: mismatch expected word=%h bytes=%0d kind=%0d st=%0d fin=%0d",
                                 $time, e.word, e.bytes, e.kind, e.status, e.fin);
                        $display("%0t:          actual   word=%h bytes=%0d kind=%0d st=%0d fin=%0d",
                                 $time, m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tuser,
                                 m_axis_tdata[69:68], m_axis_tlast);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (quiet_cycles >= 20000) begin
            $display("FAIL");
            $finish;
        end
    end

    int random_sent;

    initial begin
        ccm_item_t it;
        bit        pressed;
        failed = 1'b0;
        pressed = 1'b0;
        hold_input = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 84;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n = 1'b0;
        mdl_key_hi = '0; mdl_key_lo = '0; mdl_tag_len = TAG_LEN_RESET; mdl_mode = 1'b0;
        for (int i = 0; i < 16; i++) begin
            mac_state[i] = 0; ks_block[i] = 0; blk_buf[i] = 0; rx_tag[i] = 0;
        end
        for (int i = 0; i < 13; i++) nonce_b[i] = 0;
        ctr_val = 0; pay_left = 0; fill_cnt = 0; aad_left = 0; mdl_phase = PH_IDLE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, first with the reset key and tag length.
        queue_message(0, 0, 0, 0);
        queue_message(30, 17, 0, 0);
        it = make_header(31, 5);
        pending_items.push_back(it);
        pending_items.push_back(make_item(CMD_PAY, '1, 8, 1'b1));
        pending_items.push_back(make_item(CMD_TAG, '1, 8, 1'b1));
        queue_message(3, 9, 0, 0);
        pending_items.push_back(make_item(CMD_AAD, '0, 0, 1'b0));
        queue_message(14, 5, 0, 0);
        drain_engine();

        write_reg(REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_KEY_LOW, 64'h0000_0000_0000_0000);
        write_reg(REG_TAG_LEN, 64'd16);
        write_reg(REG_MODE, 64'd0);
        queue_message(1, 16, 0, 0);
        queue_message(0, 0, 0, 0);
        drain_engine();

        write_reg(REG_TAG_LEN, 64'd31);
        write_reg(REG_MODE, 64'd1);
        queue_message(2, 8, 1, 1);
        queue_message(0, 0, 1, 0);
        queue_message(5, 3, 1, 1);
        drain_engine();
        write_reg(REG_TAG_LEN, 64'd0);
        queue_message(0, 1, 1, 1);
        drain_engine();

        // Random part across three idling phases and several register settings.
        random_sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 84 : 0;
            recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 19 : 0;
            while (random_sent < (ph + 1) * 140) begin
                int before_sz, dice;
                if ($urandom_range(0, 5) == 0) begin
                    drain_engine();
                    write_reg(REG_KEY_HIGH, {$urandom, $urandom});
                    write_reg(REG_KEY_LOW, {$urandom, $urandom});
                    write_reg(REG_TAG_LEN, $urandom_range(0, 31));
                    write_reg(REG_MODE, $urandom_range(0, 1));
                end
                before_sz = pending_items.size();
                dice = $urandom_range(0, 19);
                if (dice == 0)
                    pending_items.push_back(make_header($urandom_range(31, 31), $urandom));
                else if (dice == 1)
                    pending_items.push_back(make_item(cmd_t'($urandom_range(0, 3)),
                                                      {$urandom, $urandom},
                                                      $urandom_range(0, 15),
                                                      1'($urandom)));
                else if (dice == 2)
                    queue_message($urandom_range(0, 30), $urandom_range(0, 4), mdl_mode, 1);
                else
                    queue_message($urandom_range(0, 30),
                                  ($urandom_range(0, 30) == 0) ? $urandom_range(100, 300)
                                                               : $urandom_range(0, 40),
                                  mdl_mode, $urandom_range(0, 3) != 0);
                random_sent += pending_items.size() - before_sz;
                while (pending_items.size() > 40) @(posedge clk);
                if (!pressed && random_sent > 120 && ph == 0) begin
                    // Hold the input until the engine has delivered everything.
                    pressed = 1'b1;
                    while (pending_items.size() > 0) @(posedge clk);
                    hold_input = 1'b1;
                    while (expected_results.size() > 0) @(posedge clk);
                    hold_input = 1'b0;
                end
            end
        end
        drain_engine();
        if (!failed)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
